FILE: hw/rtl/ppc_pkg.sv
// Shared types and constants of the point proximity classifier.
package ppc_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned WIDE_W = 32;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned HIT_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DIST   = 3'd0,
    REG_COLL_DIST  = 3'd1,
    REG_CORR_WIDTH = 3'd2,
    REG_CORR_HGT   = 3'd3,
    REG_HIT_LIMIT  = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    BAND_KEEP     = 3'd0,
    BAND_CORRIDOR = 3'd1,
    BAND_NEAR     = 3'd2,
    BAND_MIDDLE   = 3'd3,
    BAND_FAR      = 3'd4
  } band_e;

  typedef struct packed {
    logic [13:0] min_dist;
    logic [13:0] coll_dist;
    logic [14:0] corr_width;
    logic [14:0] corr_height;
    logic [15:0] hit_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      pvalid;
    logic                      last;
  } point_t;

  typedef struct packed {
    logic [HIT_W-1:0] count;
    logic             collide;
  } hit_stat_t;

endpackage

FILE: hw/rtl/point_proximity_classifier.sv
// Top level of the point proximity classifier: point register, banding, result register.
//
// Points enter on the s_axis channel: tdata carries point_x, point_y and point_z,
// tuser the point valid bit and tlast the frame end marker. One result word per
// point leaves on the m_axis channel with the band class, the hit count and the
// collision flag in tdata and the frame end echo in tlast.
// Configuration registers are written through cfg_valid_i/cfg_index_i/cfg_data_i,
// which is always ready; write them only while no point is in flight.
// A word accepted at a clock edge is held in the point register, where it is banded
// and counted, and its result is then registered into the output register, from
// which it is presented on m_axis; the point register passes its word on only
// when the output register is empty or its word is being taken.
// Throughput is one point per cycle while the receiver keeps m_axis_tready high.
// When the receiver stalls, the output register holds its word and the point
// register holds one more; s_axis_tready drops only when both are full.
// Reset empties both stages, loads the register defaults and clears the hit
// count and collision flag. The count and flag clear after each frame end word.
module point_proximity_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] point_x, [31:16] point_y, [47:32] point_z
  input  logic [ppc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [0] point_valid
  input  logic                           s_axis_tuser,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] band_class, [18:3] hit_count, [19] collide, [23:20] zero
  output logic [ppc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ppc_pkg::*;

  cfg_t      cfg;
  point_t    pt_q, pt_d;
  logic      pt_valid_q, pt_valid_d;
  band_e     band;
  hit_stat_t stat;
  logic      out_valid_q, out_valid_d;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;
  logic      out_last_q, out_last_d;
  logic      out_adv, pt_fire, in_fire;

  ppc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ppc_classify u_classify (
    .pt_i   (pt_q),
    .cfg_i  (cfg),
    .band_o (band)
  );

  ppc_hit_counter u_counter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (pt_fire),
    .hit_i   (band == BAND_CORRIDOR),
    .last_i  (pt_q.last),
    .limit_i (cfg.hit_limit),
    .stat_o  (stat)
  );

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign pt_fire       = pt_valid_q && out_adv;
  assign s_axis_tready = !pt_valid_q || out_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    pt_valid_d = pt_valid_q;
    pt_d       = pt_q;
    if (s_axis_tready) begin
      pt_valid_d = s_axis_tvalid;
    end
    if (in_fire) begin
      pt_d.x      = s_axis_tdata[15:0];
      pt_d.y      = s_axis_tdata[31:16];
      pt_d.z      = s_axis_tdata[47:32];
      pt_d.pvalid = s_axis_tuser;
      pt_d.last   = s_axis_tlast;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (out_adv) begin
      out_valid_d = pt_valid_q;
    end
    if (pt_fire) begin
      out_data_d = {4'b0000, stat.collide, stat.count, band};
      out_last_d = pt_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pt_valid_q  <= pt_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q       <= pt_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (pt_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while a stage was free");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_fire |=> out_valid_q)
    else $error("registered point produced no result word");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_data_q)))
    else $error("result word changed while stalled");

endmodule

FILE: hw/rtl/ppc_cfg_regs.sv
// Configuration register file of the point proximity classifier.
module ppc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ppc_pkg::cfg_t                 cfg_o
);
  import ppc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MIN_DIST:   cfg_d.min_dist    = cfg_data_i[13:0];
        REG_COLL_DIST:  cfg_d.coll_dist   = cfg_data_i[13:0];
        REG_CORR_WIDTH: cfg_d.corr_width  = cfg_data_i[14:0];
        REG_CORR_HGT:   cfg_d.corr_height = cfg_data_i[14:0];
        REG_HIT_LIMIT:  cfg_d.hit_limit   = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_dist    <= 14'd500;
      cfg_q.coll_dist   <= 14'd4000;
      cfg_q.corr_width  <= 15'd1200;
      cfg_q.corr_height <= 15'd400;
      cfg_q.hit_limit   <= 16'd20;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/ppc_classify.sv
// Distance banding and corridor test for one registered point.
module ppc_classify (
  input  ppc_pkg::point_t pt_i,
  input  ppc_pkg::cfg_t   cfg_i,
  output ppc_pkg::band_e  band_o
);
  import ppc_pkg::*;

  logic signed [2*COORD_W-1:0] sx, sy, sz;
  logic [WIDE_W-1:0] d2, mn2, co2, far2;
  logic [COORD_W:0]  ay, az;
  logic [COORD_W+1:0] ay2, az2;
  logic in_y, in_z;

  always_comb begin
    sx   = pt_i.x * pt_i.x;
    sy   = pt_i.y * pt_i.y;
    sz   = pt_i.z * pt_i.z;
    d2   = WIDE_W'(unsigned'(sx)) + WIDE_W'(unsigned'(sy)) + WIDE_W'(unsigned'(sz));
    mn2  = WIDE_W'(cfg_i.min_dist) * WIDE_W'(cfg_i.min_dist);
    co2  = WIDE_W'(cfg_i.coll_dist) * WIDE_W'(cfg_i.coll_dist);
    far2 = {co2[WIDE_W-3:0], 2'b00};
    ay   = pt_i.y[COORD_W-1] ? (COORD_W+1)'(-$signed({pt_i.y[COORD_W-1], pt_i.y}))
                             : {1'b0, pt_i.y};
    az   = pt_i.z[COORD_W-1] ? (COORD_W+1)'(-$signed({pt_i.z[COORD_W-1], pt_i.z}))
                             : {1'b0, pt_i.z};
    ay2  = {ay, 1'b0};
    az2  = {az, 1'b0};
    in_y = ay2 < (COORD_W+2)'(cfg_i.corr_width);
    in_z = az2 < (COORD_W+2)'(cfg_i.corr_height);

    if (!pt_i.pvalid) begin
      band_o = BAND_KEEP;
    end else if (in_y && in_z && (d2 < co2) && (d2 > mn2)) begin
      band_o = BAND_CORRIDOR;
    end else if (d2 < mn2) begin
      band_o = BAND_KEEP;
    end else if (d2 < co2) begin
      band_o = BAND_NEAR;
    end else if (d2 < far2) begin
      band_o = BAND_MIDDLE;
    end else begin
      band_o = BAND_FAR;
    end
  end

endmodule

FILE: hw/rtl/ppc_hit_counter.sv
// Per-frame corridor hit counter and collision flag.
module ppc_hit_counter (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  logic                    hit_i,
  input  logic                    last_i,
  input  logic [15:0]             limit_i,
  output ppc_pkg::hit_stat_t      stat_o
);
  import ppc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam logic [WIDE_W-1:0] HitMax = WIDE_W'({HIT_W{1'b1}});

  logic [COUNT_BITS-1:0] hits_q, hits_d, hits_inc;
  logic                  flag_q, flag_d, flag_new;
  logic [WIDE_W-1:0]     hits_wide;

  always_comb begin
    hits_inc  = (hit_i && (hits_q != CountMax)) ? hits_q + 1'b1 : hits_q;
    flag_new  = flag_q | (hit_i && (WIDE_W'(hits_inc) > WIDE_W'(limit_i)));
    hits_wide = WIDE_W'(hits_inc);
    stat_o.count   = (hits_wide > HitMax) ? {HIT_W{1'b1}} : hits_wide[HIT_W-1:0];
    stat_o.collide = flag_new;
    hits_d = hits_q;
    flag_d = flag_q;
    if (fire_i) begin
      hits_d = last_i ? '0 : hits_inc;
      flag_d = last_i ? 1'b0 : flag_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q <= '0;
      flag_q <= 1'b0;
    end else begin
      hits_q <= hits_d;
      flag_q <= flag_d;
    end
  end

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && last_i) |=> (hits_q == '0 && !flag_q))
    else $error("hit state not cleared after frame end");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !last_i) |=> (hits_q >= $past(hits_q)))
    else $error("hit count decreased within a frame");

  a_flag_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flag_q) |-> $past(fire_i && hit_i))
    else $error("collision flag rose without a corridor hit");

endmodule

FILE: tb/sv/testbench.sv
// Testbench of the point proximity classifier: streamed points, random idling, predicted bands.
`timescale 1ns / 1ps

module testbench;
  import ppc_pkg::*;

  typedef struct packed {
    band_e            band;
    logic [HIT_W-1:0] count;
    logic             collide;
    logic             done;
  } band_word_t;

  typedef enum int {
    PT_CORRIDOR,
    PT_EDGE,
    PT_SPREAD,
    PT_NOISE
  } pt_kind_e;

  class proximity_scoreboard;
    cfg_t                  cfg;
    logic [COUNT_BITS-1:0] hits;
    logic                  collide;
    band_word_t            expected_words[$];
    int                    errors;

    function new();
      cfg.min_dist    = 14'd500;
      cfg.coll_dist   = 14'd4000;
      cfg.corr_width  = 15'd1200;
      cfg.corr_height = 15'd400;
      cfg.hit_limit   = 16'd20;
      hits            = '0;
      collide         = 1'b0;
      errors          = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MIN_DIST:   cfg.min_dist    = data[13:0];
        REG_COLL_DIST:  cfg.coll_dist   = data[13:0];
        REG_CORR_WIDTH: cfg.corr_width  = data[14:0];
        REG_CORR_HGT:   cfg.corr_height = data[14:0];
        REG_HIT_LIMIT:  cfg.hit_limit   = data[15:0];
        default: ;
      endcase
    endfunction

    function void note_point(point_t p);
      longint     x, y, z, ay, az, d2, mn2, co2;
      band_word_t w;
      x = $signed(p.x);
      y = $signed(p.y);
      z = $signed(p.z);
      w.band = BAND_KEEP;
      if (p.pvalid) begin
        d2  = x * x + y * y + z * z;
        mn2 = longint'(cfg.min_dist) * longint'(cfg.min_dist);
        co2 = longint'(cfg.coll_dist) * longint'(cfg.coll_dist);
        ay  = (y < 0) ? -y : y;
        az  = (z < 0) ? -z : z;
        if (2 * ay < longint'(cfg.corr_width) && 2 * az < longint'(cfg.corr_height) &&
            d2 < co2 && d2 > mn2) begin
          w.band = BAND_CORRIDOR;
          if (hits != '1) hits = hits + 1'b1;
          if (longint'(hits) > longint'(cfg.hit_limit)) collide = 1'b1;
        end else if (d2 < mn2) begin
          w.band = BAND_KEEP;
        end else if (d2 < co2) begin
          w.band = BAND_NEAR;
        end else if (d2 < 4 * co2) begin
          w.band = BAND_MIDDLE;
        end else begin
          w.band = BAND_FAR;
        end
      end
      w.count   = (longint'(hits) > 65535) ? '1 : HIT_W'(hits);
      w.collide = collide;
      w.done    = p.last;
      expected_words = {expected_words, w};
      if (p.last) begin
        hits    = '0;
        collide = 1'b0;
      end
    endfunction

    task report(string msg);
      if (errors < 50) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [M_TDATA_W-1:0] word, logic last);
      band_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("word %h arrived with nothing pending", word));
        return;
      end
      w = expected_words.pop_front();
      if (word[2:0] !== w.band)
        report($sformatf("band %0d, want %0d", word[2:0], w.band));
      if (word[18:3] !== w.count)
        report($sformatf("hit count %0d, want %0d", word[18:3], w.count));
      if (word[19] !== w.collide)
        report($sformatf("collide %b, want %b", word[19], w.collide));
      if (word[23:20] !== 4'd0)
        report($sformatf("pad bits %b, want zero", word[23:20]));
      if (last !== w.done)
        report($sformatf("tlast %b, want %b", last, w.done));
    endtask
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  proximity_scoreboard sb;
  int burst_left   = 0;
  bit sender_quiet = 1'b0;
  bit rx_quiet     = 1'b0;
  int stall_left   = 0;
  int rx_mode      = 0;
  int rx_cycle     = 0;

  point_proximity_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
    if (rx_quiet || rx_mode == 0) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 7) < rx_mode * 2) stall_left = $urandom_range(1, rx_mode * 3);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  function automatic logic signed [COORD_W-1:0] clamp16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return COORD_W'(v);
  endfunction

  function automatic int rand_sign(int v);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic point_t make_point(pt_kind_e kind);
    point_t p;
    int     mn, co, hy, hz, r, span;
    mn = int'(sb.cfg.min_dist);
    co = int'(sb.cfg.coll_dist);
    hy = (sb.cfg.corr_width > 0) ? (int'(sb.cfg.corr_width) - 1) / 2 : 0;
    hz = (sb.cfg.corr_height > 0) ? (int'(sb.cfg.corr_height) - 1) / 2 : 0;
    p.pvalid = 1'b1;
    p.last   = 1'b0;
    case (kind)
      PT_CORRIDOR: begin
        p.x = clamp16(rand_sign($urandom_range(co, mn)));
        p.y = clamp16(int'($urandom_range(0, 2 * hy)) - hy);
        p.z = clamp16(int'($urandom_range(0, 2 * hz)) - hz);
      end
      PT_EDGE: begin
        case ($urandom_range(0, 7))
          0: r = mn;
          1: r = mn + 1;
          2: r = co - 1;
          3: r = co;
          4: r = 2 * co - 1;
          5: r = 2 * co;
          6: r = 2 * co + 1;
          default: r = 0;
        endcase
        p.x = clamp16(rand_sign(r));
        case ($urandom_range(0, 3))
          0: p.y = '0;
          1: p.y = clamp16(rand_sign(hy));
          2: p.y = clamp16(rand_sign(hy + 1));
          default: p.y = clamp16(int'($urandom_range(0, 2 * hy)) - hy);
        endcase
        case ($urandom_range(0, 3))
          0: p.z = '0;
          1: p.z = clamp16(rand_sign(hz));
          2: p.z = clamp16(rand_sign(hz + 1));
          default: p.z = clamp16(int'($urandom_range(0, 2 * hz)) - hz);
        endcase
      end
      PT_SPREAD: begin
        span = 2 * co + 200;
        p.x = clamp16(int'($urandom_range(0, 2 * span)) - span);
        p.y = clamp16(int'($urandom_range(0, 2 * span)) - span);
        p.z = clamp16(int'($urandom_range(0, 2 * span)) - span);
      end
      default: begin
        p.x      = COORD_W'($urandom);
        p.y      = COORD_W'($urandom);
        p.z      = COORD_W'($urandom);
        p.pvalid = 1'($urandom_range(0, 1));
        p.last   = ($urandom_range(0, 7) == 0);
      end
    endcase
    return p;
  endfunction

  task automatic send_point(point_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (sender_quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.z, p.y, p.x};
    s_axis_tuser  <= p.pvalid;
    s_axis_tlast  <= p.last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_point(p);
    burst_left--;
  endtask

  task automatic send_xyz(int x, int y, int z, bit pvalid, bit last);
    point_t p;
    p.x      = clamp16(x);
    p.y      = clamp16(y);
    p.z      = clamp16(z);
    p.pvalid = pvalid;
    p.last   = last;
    send_point(p);
  endtask

  task automatic stop_points();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while (sb.expected_words.size() > 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic apply_config(int mn, int co, int wd, int ht, int lm);
    wait_drained();
    cfg_write(REG_MIN_DIST, {2'($urandom), 14'(mn)});
    cfg_write(REG_COLL_DIST, {2'($urandom), 14'(co)});
    cfg_write(REG_CORR_WIDTH, {1'($urandom), 15'(wd)});
    cfg_write(REG_CORR_HGT, {1'($urandom), 15'(ht)});
    cfg_write(REG_HIT_LIMIT, 16'(lm));
    cfg_write(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom));
  endtask

  task automatic run_frames(int n);
    int       sent, len, pick;
    bit       broken;
    pt_kind_e kind;
    point_t   p;
    sent = 0;
    while (sent < n) begin
      len    = $urandom_range(1, 64);
      if (len > n - sent) len = n - sent;
      broken = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 9);
        if (broken || pick == 9) kind = PT_NOISE;
        else if (pick < 5) kind = PT_CORRIDOR;
        else if (pick < 7) kind = PT_EDGE;
        else kind = PT_SPREAD;
        p = make_point(kind);
        if (!broken && kind != PT_NOISE) begin
          p.pvalid = ($urandom_range(0, 15) != 0);
          p.last   = (i == len - 1);
        end
        send_point(p);
        sent++;
      end
    end
    stop_points();
  endtask

  initial begin
    #20_000_000;
    $display("** point_proximity_classifier: FAILED **");
    $finish;
  end

  initial begin
    int mn, co;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_xyz(0, 0, 0, 1, 0);
    send_xyz(500, 0, 0, 1, 0);
    send_xyz(501, 0, 0, 1, 0);
    send_xyz(3999, 0, 0, 1, 0);
    send_xyz(4000, 0, 0, 1, 0);
    send_xyz(7999, 0, 0, 1, 0);
    send_xyz(8000, 0, 0, 1, 0);
    send_xyz(1000, 600, 0, 1, 0);
    send_xyz(1000, -599, 0, 1, 0);
    send_xyz(1000, 0, 200, 1, 0);
    send_xyz(-1000, 0, -199, 1, 0);
    send_xyz(1000, 0, 0, 0, 0);
    send_xyz(-32768, -32768, -32768, 1, 0);
    send_xyz(32767, 32767, 32767, 1, 0);
    send_xyz(0, 0, 499, 1, 0);
    send_xyz(2000, 0, 0, 0, 1);
    send_xyz(2000, 0, 0, 1, 1);
    send_xyz(2000, 0, 0, 1, 0);
    run_frames(300);

    apply_config(0, 0, 0, 0, 0);
    run_frames(80);
    apply_config(16383, 16383, 32767, 32767, 65535);
    run_frames(80);
    apply_config(0, 16383, 32767, 32767, 0);
    sender_quiet = 1'b1;
    rx_quiet     = 1'b1;
    run_frames(80);
    sender_quiet = 1'b0;
    rx_quiet     = 1'b0;
    repeat (5) begin
      mn = $urandom_range(0, 3000);
      co = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                       : ((mn + 6000 > 16383) ? 16383 : mn + $urandom_range(1, 6000));
      apply_config(mn, co, $urandom_range(0, 4000), $urandom_range(0, 2000),
                   $urandom_range(0, 40));
      run_frames(120);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.expected_words.size() != 0)
      sb.report($sformatf("%0d words never arrived", sb.expected_words.size()));
    if (sb.errors == 0) begin
      $display("** point_proximity_classifier: PASSED **");
    end else begin
      $display("** point_proximity_classifier: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ppc_pkg.sv
hw/rtl/ppc_cfg_regs.sv
hw/rtl/ppc_classify.sv
hw/rtl/ppc_hit_counter.sv
hw/rtl/point_proximity_classifier.sv
tb/sv/testbench.sv
